### sv/yrc_pkg.sv
`timescale 1ns / 1ps
// types, constants and helpers shared by the ycbcr 4:2:0 to rgb converter
// no dependencies

package yrc_pkg;

    localparam int PIX_W                 = 8;
    localparam int COORD_W               = 12;
    localparam int CFG_W                 = 13;
    localparam int CFG_IDX_W             = 2;
    localparam int MSEL_W                = 3;
    localparam int COEF_W                = 18;
    localparam int DIFF_W                = 9;
    localparam int TERM_W                = 28;
    localparam int FRAC_W                = 16;
    localparam int MAX_DIMENSION_DEFAULT = 4096;

    localparam int Y_GAIN        = 76309;
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int ROUND_HALF    = 32768;

    localparam logic [MSEL_W-1:0] MATRIX_SELECT_RESET = MSEL_W'(1);
    localparam logic [CFG_W-1:0]  FRAME_WIDTH_RESET   = CFG_W'(720);
    localparam logic [CFG_W-1:0]  FRAME_HEIGHT_RESET  = CFG_W'(576);

    localparam logic [1:0] LAST_PIXEL = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_SELECT = 2'd0,
        CFG_FRAME_WIDTH   = 2'd1,
        CFG_FRAME_HEIGHT  = 2'd2
    } cfg_idx_e;

    typedef struct packed {
        logic [COEF_W-1:0] crv;
        logic [COEF_W-1:0] cbu;
        logic [COEF_W-1:0] cgu;
        logic [COEF_W-1:0] cgv;
    } coef_t;

    localparam coef_t COEF_TABLE [8] = '{
        '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903},
        '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903},
        '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
        '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
        '{crv: 18'd104448, cbu: 18'd132798, cgu: 18'd24759, cgv: 18'd53109},
        '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
        '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279},
        '{crv: 18'd117579, cbu: 18'd136230, cgu: 18'd16907, cgv: 18'd35559}
    };

    typedef struct packed {
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] luma_top_left;
        logic [PIX_W-1:0] luma_top_right;
        logic [PIX_W-1:0] luma_bottom_left;
        logic [PIX_W-1:0] luma_bottom_right;
    } block_t;

    typedef struct packed {
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last_of_block;
        logic               end_of_frame;
    } pixel_t;

    // frame position of a block's top-left pixel
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last_block;
    } pos_t;

    typedef struct packed {
        logic [3:0][PIX_W-1:0]    luma;
        logic signed [TERM_W-1:0] r_term;
        logic signed [TERM_W-1:0] g_term;
        logic signed [TERM_W-1:0] b_term;
        pos_t                     pos;
    } work_t;

    // floor(v / 2^16) clamped to 0..255
    function automatic logic [PIX_W-1:0] sat_shift(input logic signed [TERM_W-1:0] v);
        logic [PIX_W-1:0] r;
        if (v[TERM_W-1])
            r = '0;
        else if (|v[TERM_W-2:FRAC_W+PIX_W])
            r = '1;
        else
            r = v[FRAC_W+PIX_W-1:FRAC_W];
        return r;
    endfunction

endpackage

### sv/yrc_stream_if.sv
`timescale 1ns / 1ps
// valid/ready stream channel carrying one payload beat
// payload type given by parameter, usually from yrc_pkg

interface yrc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/yuv420_to_rgb32_convert.sv
`timescale 1ns / 1ps
// top level of the ycbcr 4:2:0 to rgb converter with its register file
// depends on yrc_pkg, yrc_stream_if, yrc_position, yrc_chroma, yrc_pixel

// Each beat on yuv_block carries one Cb/Cr pair and its 2x2 luma block and
// produces four beats on rgb_pixel (top-left, top-right, bottom-left,
// bottom-right), tagged with frame position, last_of_block and end_of_frame.
// The pixel port moves one beat per cycle while rgb_pixel.ready is high. A new
// block is taken while the previous one is still being sent. Blocks pass the
// input, chroma term and serializer block registers before the output register.
// Registers (matrix_select, frame_width, frame_height) are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the block
// is idle, which the block itself does not enforce. Sizes are clamped to
// 2..MAX_DIMENSION and rounded down to even, dropping an odd last row or column.

module yuv420_to_rgb32_convert #(
    parameter int MAX_DIMENSION = yrc_pkg::MAX_DIMENSION_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrc_pkg::CFG_W-1:0]     cfg_data,
    yrc_stream_if.sink                    yuv_block,
    yrc_stream_if.source                  rgb_pixel
);

    logic [yrc_pkg::MSEL_W-1:0] matrix_select_reg, matrix_select_next;
    logic [yrc_pkg::CFG_W-1:0]  frame_width_reg, frame_width_next;
    logic [yrc_pkg::CFG_W-1:0]  frame_height_reg, frame_height_next;

    logic            accept;
    logic            blk_ready;
    yrc_pkg::pos_t   pos;
    logic            work_valid, work_ready;
    yrc_pkg::work_t  work;
    logic            pix_valid;
    yrc_pkg::pixel_t pix;

    always_comb
    begin
        matrix_select_next = matrix_select_reg;
        frame_width_next   = frame_width_reg;
        frame_height_next  = frame_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                yrc_pkg::CFG_MATRIX_SELECT:
                    matrix_select_next = cfg_data[yrc_pkg::MSEL_W-1:0];
                yrc_pkg::CFG_FRAME_WIDTH:
                    frame_width_next = cfg_data;
                yrc_pkg::CFG_FRAME_HEIGHT:
                    frame_height_next = cfg_data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_select_reg <= yrc_pkg::MATRIX_SELECT_RESET;
            frame_width_reg   <= yrc_pkg::FRAME_WIDTH_RESET;
            frame_height_reg  <= yrc_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            matrix_select_reg <= matrix_select_next;
            frame_width_reg   <= frame_width_next;
            frame_height_reg  <= frame_height_next;
        end
    end

    assign accept          = yuv_block.valid && blk_ready;
    assign yuv_block.ready = blk_ready;

    yrc_position #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pos          (pos)
    );

    yrc_chroma u_chroma (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (yuv_block.valid),
        .in_ready      (blk_ready),
        .in_data       (yuv_block.data),
        .in_pos        (pos),
        .matrix_select (matrix_select_reg),
        .work_valid    (work_valid),
        .work_ready    (work_ready),
        .work          (work)
    );

    yrc_pixel u_pixel (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work),
        .pix_valid  (pix_valid),
        .pix_ready  (rgb_pixel.ready),
        .pix        (pix)
    );

    assign rgb_pixel.valid = pix_valid;
    assign rgb_pixel.data  = pix;

endmodule

### sv/yrc_position.sv
`timescale 1ns / 1ps
// block position tracker: raster block counters with frame wrap and size clamp
// depends on yrc_pkg

module yrc_position #(
    parameter int MAX_DIMENSION = yrc_pkg::MAX_DIMENSION_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [yrc_pkg::CFG_W-1:0] frame_width,
    input  logic [yrc_pkg::CFG_W-1:0] frame_height,
    output yrc_pkg::pos_t             pos
);

    localparam int MAX_W = $clog2(MAX_DIMENSION + 1);
    localparam int DW    = (MAX_W > yrc_pkg::CFG_W) ? MAX_W : yrc_pkg::CFG_W;
    localparam int BW    = DW - 1;
    localparam int BK    = $clog2(MAX_DIMENSION / 2);
    localparam logic [DW-1:0] DIM_MAX = DW'(MAX_DIMENSION);
    localparam logic [DW-1:0] DIM_MIN = DW'(2);

    function automatic logic [BW-1:0] blocks_of(input logic [DW-1:0] dim);
        logic [DW-1:0] d;
        d = dim;
        if (d < DIM_MIN)
            d = DIM_MIN;
        if (d > DIM_MAX)
            d = DIM_MAX;
        return d[DW-1:1];
    endfunction

    logic [BK-1:0] col_reg, col_next;
    logic [BK-1:0] row_reg, row_next;
    logic [BW-1:0] bw, bh;
    logic [BW-1:0] col_a, row_a, col_n, row_n;

    always_comb
    begin
        bw = blocks_of(DW'(frame_width));
        bh = blocks_of(DW'(frame_height));

        // position left beyond a shrunk frame
        if (BW'(col_reg) >= bw)
        begin
            col_a = '0;
            row_a = BW'(row_reg) + 1'b1;
        end
        else
        begin
            col_a = BW'(col_reg);
            row_a = BW'(row_reg);
        end
        if (row_a >= bh)
            row_a = '0;

        col_n = col_a + 1'b1;
        row_n = row_a;
        if (col_n >= bw)
        begin
            col_n = '0;
            row_n = row_a + 1'b1;
            if (row_n >= bh)
                row_n = '0;
        end

        col_next = advance ? BK'(col_n) : col_reg;
        row_next = advance ? BK'(row_n) : row_reg;

        pos.x          = yrc_pkg::COORD_W'({col_a, 1'b0});
        pos.y          = yrc_pkg::COORD_W'({row_a, 1'b0});
        pos.last_block = (col_a == bw - 1'b1) && (row_a == bh - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### sv/yrc_chroma.sv
`timescale 1ns / 1ps
// input register and chroma term stage: products of cb/cr with the matrix
// depends on yrc_pkg

module yrc_chroma (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  yrc_pkg::block_t            in_data,
    input  yrc_pkg::pos_t              in_pos,
    input  logic [yrc_pkg::MSEL_W-1:0] matrix_select,
    output logic                       work_valid,
    input  logic                       work_ready,
    output yrc_pkg::work_t             work
);

    localparam int TW = yrc_pkg::TERM_W;
    localparam int VW = yrc_pkg::DIFF_W;
    localparam int CW = yrc_pkg::COEF_W;

    logic            a_valid_reg, a_valid_next;
    yrc_pkg::block_t a_blk_reg;
    yrc_pkg::pos_t   a_pos_reg;
    logic            b_valid_reg, b_valid_next;
    yrc_pkg::work_t  b_work_reg, b_work_next;

    logic            accept, a_adv, b_adv, b_free;
    yrc_pkg::coef_t  c;
    logic signed [VW-1:0] u, v;
    logic signed [CW:0]   crv, cbu, cgu, cgv;

    always_comb
    begin
        b_adv    = b_valid_reg && work_ready;
        b_free   = !b_valid_reg || b_adv;
        a_adv    = a_valid_reg && b_free;
        in_ready = !a_valid_reg || a_adv;
        accept   = in_valid && in_ready;

        a_valid_next = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
        b_valid_next = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
    end

    always_comb
    begin
        c   = yrc_pkg::COEF_TABLE[matrix_select];
        crv = $signed({1'b0, c.crv});
        cbu = $signed({1'b0, c.cbu});
        cgu = $signed({1'b0, c.cgu});
        cgv = $signed({1'b0, c.cgv});
        u   = VW'($signed({1'b0, a_blk_reg.cb}) - yrc_pkg::CHROMA_OFFSET);
        v   = VW'($signed({1'b0, a_blk_reg.cr}) - yrc_pkg::CHROMA_OFFSET);

        b_work_next.luma   = {a_blk_reg.luma_bottom_right, a_blk_reg.luma_bottom_left,
                              a_blk_reg.luma_top_right, a_blk_reg.luma_top_left};
        b_work_next.r_term = TW'(crv) * TW'(v);
        b_work_next.g_term = TW'(cgu) * TW'(u) + TW'(cgv) * TW'(v)
                             - TW'(yrc_pkg::ROUND_HALF);
        b_work_next.b_term = TW'(cbu) * TW'(u) + TW'(yrc_pkg::ROUND_HALF);
        b_work_next.pos    = a_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_blk_reg <= in_data;
            a_pos_reg <= in_pos;
        end
        if (a_adv)
            b_work_reg <= b_work_next;
    end

    assign work_valid = b_valid_reg;
    assign work       = b_work_reg;

endmodule

### sv/yrc_pixel.sv
`timescale 1ns / 1ps
// pixel serializer: one luma a cycle unless stalled, rgb sums, saturation, output register
// depends on yrc_pkg

module yrc_pixel (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            work_valid,
    output logic            work_ready,
    input  yrc_pkg::work_t  work,
    output logic            pix_valid,
    input  logic            pix_ready,
    output yrc_pkg::pixel_t pix
);

    localparam int TW = yrc_pkg::TERM_W;
    localparam int VW = yrc_pkg::DIFF_W;

    logic            s_valid_reg, s_valid_next;
    yrc_pkg::work_t  s_work_reg;
    logic [1:0]      cnt_reg, cnt_next;
    logic            o_valid_reg, o_valid_next;
    yrc_pkg::pixel_t o_pix_reg, o_pix_next;

    logic                  o_load, emit, s_free, last_pix;
    logic signed [VW-1:0]  ys;
    logic signed [TW-1:0]  y, sum_r, sum_g, sum_b;

    always_comb
    begin
        o_load     = !o_valid_reg || pix_ready;
        emit       = s_valid_reg && o_load;
        last_pix   = (cnt_reg == yrc_pkg::LAST_PIXEL);
        s_free     = !s_valid_reg || (emit && last_pix);
        work_ready = s_free;

        s_valid_next = s_free ? work_valid : s_valid_reg;
        cnt_next     = emit ? cnt_reg + 1'b1 : cnt_reg;
        o_valid_next = emit ? 1'b1 : (pix_ready ? 1'b0 : o_valid_reg);
    end

    always_comb
    begin
        ys    = VW'($signed({1'b0, s_work_reg.luma[cnt_reg]}) - yrc_pkg::LUMA_OFFSET);
        y     = TW'(ys) * TW'(yrc_pkg::Y_GAIN);
        sum_r = y + s_work_reg.r_term;
        sum_g = y - s_work_reg.g_term;
        sum_b = y + s_work_reg.b_term;

        o_pix_next.red           = yrc_pkg::sat_shift(sum_r);
        o_pix_next.green         = yrc_pkg::sat_shift(sum_g);
        o_pix_next.blue          = yrc_pkg::sat_shift(sum_b);
        o_pix_next.pixel_x       = {s_work_reg.pos.x[yrc_pkg::COORD_W-1:1], cnt_reg[0]};
        o_pix_next.pixel_y       = {s_work_reg.pos.y[yrc_pkg::COORD_W-1:1], cnt_reg[1]};
        o_pix_next.last_of_block = last_pix;
        o_pix_next.end_of_frame  = last_pix && s_work_reg.pos.last_block;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            cnt_reg     <= cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_free && work_valid)
            s_work_reg <= work;
        if (emit)
            o_pix_reg <= o_pix_next;
    end

    assign pix_valid = o_valid_reg;
    assign pix       = o_pix_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for yuv420_to_rgb32_convert: random and directed 2x2 blocks in,
// every rgb pixel beat checked against a local predictor; depends on yrc_pkg, yrc_stream_if

module tb_top;
    import yrc_pkg::*;

    localparam int MAX_DIM      = MAX_DIMENSION_DEFAULT;
    localparam int IDLE_PCT     = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        longint crv;
        longint cbu;
        longint cgu;
        longint cgv;
    } matrix_coefs_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b1;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MATRIX_SELECT;
    logic [CFG_W-1:0]     cfg_data  = '0;

    yrc_stream_if #(.T(block_t)) yuv_if ();
    yrc_stream_if #(.T(pixel_t)) rgb_if ();

    yuv420_to_rgb32_convert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .yuv_block (yuv_if),
        .rgb_pixel (rgb_if)
    );

    block_t           queued_blocks [$];
    pixel_t           expected_pixels [$];
    logic [MSEL_W-1:0] cur_matrix;
    logic [CFG_W-1:0] cur_width;
    logic [CFG_W-1:0] cur_height;
    int               block_col;
    int               block_row;
    int               error_count = 0;
    int               cycle_count = 0;
    bit               steady      = 1'b0;

    always #5 clk = ~clk;

    function automatic matrix_coefs_t matrix_coefs(logic [MSEL_W-1:0] sel);
        case (sel)
            3'd0, 3'd1: return '{117504, 138453, 13954, 34903};
            3'd4:       return '{104448, 132798, 24759, 53109};
            3'd7:       return '{117579, 136230, 16907, 35559};
            default:    return '{104597, 132201, 25675, 53279};
        endcase
    endfunction

    function automatic int blocks_across(logic [CFG_W-1:0] dim);
        int d;
        d = dim;
        if (d < 2)
            d = 2;
        if (d > MAX_DIM)
            d = MAX_DIM;
        return d / 2;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_shift(longint v);
        longint s;
        s = v >>> 16;
        if (s < 0)
            return '0;
        if (s > 255)
            return '1;
        return s[PIX_W-1:0];
    endfunction

    // four pixels of one block at the current position, then step the position
    task automatic convert_block(block_t b);
        int               bw;
        int               bh;
        matrix_coefs_t    c;
        longint           u;
        longint           v;
        longint           r_term;
        longint           g_term;
        longint           b_term;
        longint           y;
        logic [PIX_W-1:0] luma [4];
        pixel_t           p;
        bit               last_blk;
        bw = blocks_across(cur_width);
        bh = blocks_across(cur_height);
        c = matrix_coefs(cur_matrix);
        u = longint'(b.cb) - 128;
        v = longint'(b.cr) - 128;
        r_term = c.crv * v;
        g_term = c.cgu * u + c.cgv * v - 32768;
        b_term = c.cbu * u + 32768;
        luma = '{b.luma_top_left, b.luma_top_right, b.luma_bottom_left, b.luma_bottom_right};
        // position left over from a larger frame
        if (block_col >= bw)
        begin
            block_col = 0;
            block_row++;
        end
        if (block_row >= bh)
            block_row = 0;
        last_blk = (block_col == bw - 1) && (block_row == bh - 1);
        for (int k = 0; k < 4; k++)
        begin
            y = 76309 * (longint'(luma[k]) - 16);
            p.red           = clamp_shift(y + r_term);
            p.green         = clamp_shift(y - g_term);
            p.blue          = clamp_shift(y + b_term);
            p.pixel_x       = COORD_W'(block_col * 2 + k % 2);
            p.pixel_y       = COORD_W'(block_row * 2 + k / 2);
            p.last_of_block = (k == 3);
            p.end_of_frame  = (k == 3) && last_blk;
            expected_pixels.push_back(p);
        end
        block_col++;
        if (block_col >= bw)
        begin
            block_col = 0;
            block_row++;
            if (block_row >= bh)
                block_row = 0;
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_pixel(pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            error_count++;
            $display("%0t: unexpected beat, expected none, actual x=%0d y=%0d rgb=%0d,%0d,%0d",
                     $time, got.pixel_x, got.pixel_y, got.red, got.green, got.blue);
        end
        else
        begin
            want = expected_pixels.pop_front();
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("pixel_x", want.pixel_x, got.pixel_x);
            check_field("pixel_y", want.pixel_y, got.pixel_y);
            check_field("last_of_block", want.last_of_block, got.last_of_block);
            check_field("end_of_frame", want.end_of_frame, got.end_of_frame);
        end
    endtask

    // block driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yuv_if.valid <= 1'b0;
            yuv_if.data  <= '0;
        end
        else
        begin
            if (yuv_if.valid && yuv_if.ready)
                convert_block(yuv_if.data);
            if (!yuv_if.valid || yuv_if.ready)
            begin
                if (queued_blocks.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    yuv_if.valid <= 1'b1;
                    yuv_if.data  <= queued_blocks.pop_front();
                end
                else
                    yuv_if.valid <= 1'b0;
            end
        end
    end

    // pixel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rgb_if.ready <= 1'b0;
        else
        begin
            if (rgb_if.valid && rgb_if.ready)
                check_pixel(rgb_if.data);
            rgb_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_MATRIX_SELECT: cur_matrix = value[MSEL_W-1:0];
            CFG_FRAME_WIDTH:   cur_width  = value;
            CFG_FRAME_HEIGHT:  cur_height = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_blocks.size() != 0 || yuv_if.valid || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic block_t random_block();
        block_t b;
        b.cb                = random_sample();
        b.cr                = random_sample();
        b.luma_top_left     = random_sample();
        b.luma_top_right    = random_sample();
        b.luma_bottom_left  = random_sample();
        b.luma_bottom_right = random_sample();
        return b;
    endfunction

    task automatic push_block(logic [7:0] cb, logic [7:0] cr, logic [7:0] tl, logic [7:0] tr,
                              logic [7:0] bl, logic [7:0] br);
        queued_blocks.push_back(block_t'{cb, cr, tl, tr, bl, br});
    endtask

    // upper data bits of the matrix write are junk on purpose
    task automatic run_phase(int msel, int width, int height, int count, bit calm);
        write_reg(CFG_MATRIX_SELECT, CFG_W'(($urandom_range(0, 1023) << MSEL_W) | msel));
        write_reg(CFG_FRAME_WIDTH, CFG_W'(width));
        write_reg(CFG_FRAME_HEIGHT, CFG_W'(height));
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        steady = calm;
        repeat (count) queued_blocks.push_back(random_block());
        wait_idle();
        steady = 1'b0;
    endtask

    initial
    begin
        cur_matrix = MATRIX_SELECT_RESET;
        cur_width  = FRAME_WIDTH_RESET;
        cur_height = FRAME_HEIGHT_RESET;
        block_col  = 0;
        block_row  = 0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, corner samples
        push_block(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        push_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        push_block(8'd128, 8'd128, 8'd16, 8'd16, 8'd16, 8'd16);
        push_block(8'd128, 8'd128, 8'd235, 8'd235, 8'd235, 8'd235);
        push_block(8'd128, 8'd128, 8'd0, 8'd85, 8'd170, 8'd255);
        push_block(8'd0, 8'd255, 8'd128, 8'd128, 8'd128, 8'd128);
        push_block(8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128);
        push_block(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
        push_block(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        push_block(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
        push_block(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
        push_block(8'd127, 8'd129, 8'd17, 8'd15, 8'd254, 8'd1);
        wait_idle();

        // sizes below range clamp to a single-block frame
        run_phase(0, 0, 1, 12, 1'b0);
        // sizes above range, one long row with no idling
        run_phase(7, 8191, 2, 60, 1'b1);
        // shrunk frame forces a position wrap, then repeated frame wraps
        run_phase(2, 4, 4, 30, 1'b0);
        // odd sizes drop the last row and column
        run_phase(4, 7, 5, 30, 1'b0);
        run_phase(3, 4096, 4096, 20, 1'b0);
        run_phase(5, 2, 8191, 20, 1'b0);
        run_phase(6, 1, 3, 15, 1'b0);
        for (int i = 0; i < 5; i++)
            run_phase($urandom_range(0, 7), $urandom_range(0, 24), $urandom_range(0, 16),
                      $urandom_range(30, 40), 1'b0);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
sv/yrc_pkg.sv
sv/yrc_stream_if.sv
sv/yrc_position.sv
sv/yrc_chroma.sv
sv/yrc_pixel.sv
sv/yuv420_to_rgb32_convert.sv
verif/tb_top.sv
